// ===== hdl/fre_pkg.sv =====
// Shared types, constants and the divider step for the flow record feature extractor.
// No dependencies; every other file imports this package.
package fre_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int WORD = 64;
  localparam int IMB_WIDTH = 17;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [3:0] PHASE_MAX = 4'd8;
  localparam logic [19:0] US_PER_SEC = 20'd1000000;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_OVERFLOW    = 2'd3
  } status_t;

  // one flow record
  typedef struct packed {
    logic [7:0]  protocol;
    logic        tcp_state_valid;
    logic [3:0]  conn_phase;
    logic        handshake_done;
    logic [63:0] ab_packets;
    logic [63:0] ab_captured;
    logic [63:0] ab_wire;
    logic [63:0] ba_packets;
    logic [63:0] ba_captured;
    logic [63:0] ba_wire;
    logic [63:0] first_time;
    logic [63:0] last_time;
  } rec_t;

  // one result
  typedef struct packed {
    logic [1:0]  status;
    logic        tcp_applicable;
    logic [3:0]  phase_out;
    logic        handshake_out;
    logic [63:0] duration_us;
    logic [63:0] total_packets;
    logic [63:0] total_captured;
    logic [63:0] total_wire;
    logic [63:0] mean_captured;
    logic [63:0] mean_wire;
    logic [16:0] packet_imbalance;
    logic [16:0] wire_imbalance;
  } res_t;

  // classified record handed from front to back
  typedef struct packed {
    status_t     status;
    logic        tcp;
    logic [3:0]  phase;
    logic        hs;
    logic [63:0] dur;
    logic [63:0] tp;
    logic [63:0] tc;
    logic [63:0] tw;
    logic [63:0] dp;
    logic [63:0] dw;
  } mid_t;

  typedef struct packed {
    logic [63:0] rem;
    logic        qb;
  } step_t;

  // one restoring division step; rem is below den on entry
  function automatic step_t div_step(logic [63:0] rem, logic nb, logic [63:0] den);
    logic [64:0] t;
    step_t r;
    t = {rem, nb};
    if (t >= {1'b0, den}) begin
      r.rem = 64'(t - {1'b0, den});
      r.qb  = 1'b1;
    end else begin
      r.rem = t[63:0];
      r.qb  = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/fre_if.sv =====
// Valid/ready channel interfaces for flow records and results.
// Depends on fre_pkg.
interface fre_rec_if import fre_pkg::*; ();
  logic valid;
  logic ready;
  rec_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fre_res_if import fre_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/fre_front.sv =====
// Front end: accepts flow records, runs the ordered checks, forms totals, direction differences and duration.
// Depends on fre_pkg and fre_if.
module fre_front import fre_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  fre_rec_if.sink      rec,
  output logic         mid_valid,
  output mid_t         mid_data,
  input  logic         mid_ready
);

  typedef struct packed {
    status_t     status;
    logic        tcp;
    logic [3:0]  phase;
    logic        hs;
    logic [43:0] sd;
    logic [19:0] ud;
    logic [63:0] tp;
    logic [63:0] tc;
    logic [63:0] tw;
    logic [63:0] dp;
    logic [63:0] dw;
  } sa_t;

  logic en;
  logic va;
  sa_t  sa;
  sa_t  sa_next;

  logic [64:0] sum_p, sum_c, sum_w;
  logic        dir_bad_ab, dir_bad_ba;
  logic [43:0] fs, ls;
  logic [19:0] fu, lu;
  logic        time_bad, borrow;
  logic        proto_known, proto_bad;

  assign en = !mid_valid || mid_ready;
  assign rec.ready = en;

  // classify the incoming record
  always_comb begin
    sum_p = {1'b0, rec.data.ab_packets} + {1'b0, rec.data.ba_packets};
    sum_c = {1'b0, rec.data.ab_captured} + {1'b0, rec.data.ba_captured};
    sum_w = {1'b0, rec.data.ab_wire} + {1'b0, rec.data.ba_wire};
    dir_bad_ab = (rec.data.ab_packets == '0 &&
                  (rec.data.ab_captured != '0 || rec.data.ab_wire != '0)) ||
                 (rec.data.ab_captured > rec.data.ab_wire);
    dir_bad_ba = (rec.data.ba_packets == '0 &&
                  (rec.data.ba_captured != '0 || rec.data.ba_wire != '0)) ||
                 (rec.data.ba_captured > rec.data.ba_wire);
    fs = rec.data.first_time[63:20];
    fu = rec.data.first_time[19:0];
    ls = rec.data.last_time[63:20];
    lu = rec.data.last_time[19:0];
    borrow = lu < fu;
    time_bad = (fu >= US_PER_SEC) || (lu >= US_PER_SEC) || (fs > ls) ||
               (fs == ls && fu > lu);
    proto_known = (rec.data.protocol == PROTO_TCP) || (rec.data.protocol == PROTO_UDP) ||
                  (rec.data.protocol == PROTO_ICMP);
    if (rec.data.protocol == PROTO_TCP) begin
      proto_bad = !rec.data.tcp_state_valid || (rec.data.conn_phase > PHASE_MAX);
    end else begin
      proto_bad = rec.data.tcp_state_valid;
    end

    sa_next.tcp   = rec.data.protocol == PROTO_TCP;
    sa_next.phase = rec.data.conn_phase;
    sa_next.hs    = rec.data.handshake_done;
    sa_next.sd    = 44'(ls - fs - 44'(borrow));
    sa_next.ud    = borrow ? 20'(US_PER_SEC - fu + lu) : 20'(lu - fu);
    sa_next.tp    = sum_p[63:0];
    sa_next.tc    = sum_c[63:0];
    sa_next.tw    = sum_w[63:0];
    sa_next.dp    = (rec.data.ab_packets >= rec.data.ba_packets) ?
                    rec.data.ab_packets - rec.data.ba_packets :
                    rec.data.ba_packets - rec.data.ab_packets;
    sa_next.dw    = (rec.data.ab_wire >= rec.data.ba_wire) ?
                    rec.data.ab_wire - rec.data.ba_wire :
                    rec.data.ba_wire - rec.data.ab_wire;

    // first failure wins
    priority if (!proto_known)              sa_next.status = ST_UNSUPPORTED;
    else if (proto_bad)                      sa_next.status = ST_INVALID;
    else if (dir_bad_ab || dir_bad_ba)       sa_next.status = ST_INVALID;
    else if (sum_p[64])                      sa_next.status = ST_OVERFLOW;
    else if (sum_p[63:0] == '0)              sa_next.status = ST_INVALID;
    else if (sum_c[64] || sum_w[64])         sa_next.status = ST_OVERFLOW;
    else if (time_bad)                       sa_next.status = ST_INVALID;
    else                                     sa_next.status = ST_OK;
  end

  // advance the two front stages together
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      mid_valid <= 1'b0;
    end else if (en) begin
      va        <= rec.valid;
      mid_valid <= va;
    end
    if (en) begin
      sa                <= sa_next;
      mid_data.status   <= sa.status;
      mid_data.tcp      <= sa.tcp;
      mid_data.phase    <= sa.phase;
      mid_data.hs       <= sa.hs;
      mid_data.dur      <= (64'(sa.sd) * 64'(US_PER_SEC)) + 64'(sa.ud);
      mid_data.tp       <= sa.tp;
      mid_data.tc       <= sa.tc;
      mid_data.tw       <= sa.tw;
      mid_data.dp       <= sa.dp;
      mid_data.dw       <= sa.dw;
    end
  end

endmodule

// ===== hdl/fre_queue.sv =====
// Two-entry queue between front and back halves.
// Depends on fre_pkg.
module fre_queue import fre_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  mid_t push_data,
  output logic push_ready,
  output logic pop_valid,
  output mid_t pop_data,
  input  logic pop_ready
);

  mid_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_data   = mem[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  // track fill level and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= 2'(count + 2'(push) - 2'(pop));
    end
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ===== hdl/fre_div.sv =====
// Pipelined restoring divider: floor((num << FRACTION_BITS) / den), low 64 quotient bits.
// One quotient bit per stage; depends on fre_pkg.
module fre_div import fre_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo
);

  logic [63:0] rem_s [1:WORD];
  logic [63:0] lo_s  [1:WORD];
  logic [63:0] den_s [1:WORD];
  logic [63:0] q_s   [1:WORD];
  step_t       st0;
  step_t       st   [2:WORD];

  // first step works on the high numerator bits
  assign st0 = div_step(num >> (WORD - FRACTION_BITS), num[63 - FRACTION_BITS], den);

  always_comb begin
    for (int i = 2; i <= WORD; i++) begin
      st[i] = div_step(rem_s[i-1], lo_s[i-1][63], den_s[i-1]);
    end
  end

  // advance every stage on enable
  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[1] <= st0.rem;
      lo_s[1]  <= num << (FRACTION_BITS + 1);
      den_s[1] <= den;
      q_s[1]   <= {63'b0, st0.qb};
      for (int i = 2; i <= WORD; i++) begin
        rem_s[i] <= st[i].rem;
        lo_s[i]  <= lo_s[i-1] << 1;
        den_s[i] <= den_s[i-1];
        q_s[i]   <= {q_s[i-1][62:0], st[i].qb};
      end
    end
  end

  assign quo = q_s[WORD];

endmodule

// ===== hdl/fre_back.sv =====
// Back end: four pipelined dividers for means and imbalances, side-band delay, result register.
// Depends on fre_pkg, fre_if and fre_div.
module fre_back import fre_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    mid_valid,
  input  mid_t    mid_data,
  output logic    mid_ready,
  fre_res_if.source res
);

  typedef struct packed {
    status_t     status;
    logic        tcp;
    logic [3:0]  phase;
    logic        hs;
    logic [63:0] dur;
    logic [63:0] tp;
    logic [63:0] tc;
    logic [63:0] tw;
    logic        sat_c;
    logic        sat_w;
    logic        zero_w;
  } side_t;

  logic        en;
  logic        v    [1:WORD];
  side_t       side [1:WORD];
  side_t       side0;
  logic [63:0] q_c, q_w, q_p, q_iw;
  side_t       last;
  logic        ok;

  assign en = !res.valid || res.ready;
  assign mid_ready = en;

  always_comb begin
    side0.status = mid_data.status;
    side0.tcp    = mid_data.tcp;
    side0.phase  = mid_data.phase;
    side0.hs     = mid_data.hs;
    side0.dur    = mid_data.dur;
    side0.tp     = mid_data.tp;
    side0.tc     = mid_data.tc;
    side0.tw     = mid_data.tw;
    side0.sat_c  = (mid_data.tc >> (WORD - FRACTION_BITS)) >= mid_data.tp;
    side0.sat_w  = (mid_data.tw >> (WORD - FRACTION_BITS)) >= mid_data.tp;
    side0.zero_w = mid_data.tw == '0;
  end

  fre_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_c (
    .clk(clk), .en(en), .num(mid_data.tc), .den(mid_data.tp), .quo(q_c));
  fre_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_w (
    .clk(clk), .en(en), .num(mid_data.tw), .den(mid_data.tp), .quo(q_w));
  fre_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_p (
    .clk(clk), .en(en), .num(mid_data.dp), .den(mid_data.tp), .quo(q_p));
  fre_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_iw (
    .clk(clk), .en(en), .num(mid_data.dw), .den(mid_data.tw), .quo(q_iw));

  // carry valid and side-band alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= WORD; i++) v[i] <= 1'b0;
      res.valid <= 1'b0;
    end else if (en) begin
      v[1] <= mid_valid;
      for (int i = 2; i <= WORD; i++) v[i] <= v[i-1];
      res.valid <= v[WORD];
    end
    if (en) begin
      side[1] <= side0;
      for (int i = 2; i <= WORD; i++) side[i] <= side[i-1];
    end
    if (en) begin
      res.data.status         <= last.status;
      res.data.tcp_applicable <= ok && last.tcp;
      res.data.phase_out      <= (ok && last.tcp) ? last.phase : 4'd0;
      res.data.handshake_out  <= ok && last.tcp && last.hs;
      res.data.duration_us    <= ok ? last.dur : '0;
      res.data.total_packets  <= ok ? last.tp : '0;
      res.data.total_captured <= ok ? last.tc : '0;
      res.data.total_wire     <= ok ? last.tw : '0;
      res.data.mean_captured  <= !ok ? '0 : (last.sat_c ? '1 : q_c);
      res.data.mean_wire      <= !ok ? '0 : (last.sat_w ? '1 : q_w);
      res.data.packet_imbalance <= ok ? IMB_WIDTH'(q_p) : '0;
      res.data.wire_imbalance <= (ok && !last.zero_w) ? IMB_WIDTH'(q_iw) : '0;
    end
  end

  assign last = side[WORD];
  assign ok   = last.status == ST_OK;

endmodule

// ===== hdl/flow_record_feature_extract_top.sv =====
// Top level of the flow record feature extractor: front, queue, back.
// Depends on fre_pkg, fre_if, fre_front, fre_queue, fre_back.
//
//   channel | dir | handshake    | payload
//   rec     | in  | valid/ready  | rec_t flow record
//   res     | out | valid/ready  | res_t status and features
//
// One record per cycle sustained while res is not stalled; the path runs through the front stages,
// the queue, 64 divider stages (one quotient bit per stage) and the result register.
// Reset (rst, synchronous) empties every stage and the queue.
// A stalled res holds the back pipeline; the queue lets the front keep
// taking records until it fills, then rec.ready drops.
module flow_record_feature_extract_top import fre_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fre_rec_if.sink   rec,
  fre_res_if.source res
);

  logic f_valid, f_ready, b_valid, b_ready;
  mid_t f_data, b_data;

  fre_front u_front (
    .clk(clk), .rst(rst), .rec(rec),
    .mid_valid(f_valid), .mid_data(f_data), .mid_ready(f_ready));

  fre_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_data(f_data), .push_ready(f_ready),
    .pop_valid(b_valid), .pop_data(b_data), .pop_ready(b_ready));

  fre_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst),
    .mid_valid(b_valid), .mid_data(b_data), .mid_ready(b_ready), .res(res));

endmodule

// ===== hdl/fre_checker.sv =====
// Port-level checks on the flow record feature extractor, bound to the top level.
// Depends on fre_pkg.
module fre_checker import fre_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  status,
  input logic        tcp_applicable,
  input logic [3:0]  phase_out,
  input logic [63:0] total_packets,
  input logic [16:0] packet_imbalance
);

  // hold a stalled result transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // clear result valid after reset
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // drop features on failure
  a_fail: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_OK |-> !tcp_applicable && total_packets == '0)
    else $error("failed record carries features");

  // good records have packets and a bounded ratio
  a_good: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_OK |-> total_packets != '0 && packet_imbalance <= 17'd65536)
    else $error("good record with bad totals");

  a_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid && tcp_applicable |-> phase_out <= PHASE_MAX)
    else $error("phase out of range");

endmodule

bind flow_record_feature_extract_top fre_checker u_checker (
  .clk(clk), .rst(rst),
  .res_valid(res.valid), .res_ready(res.ready),
  .status(res.data.status), .tcp_applicable(res.data.tcp_applicable),
  .phase_out(res.data.phase_out), .total_packets(res.data.total_packets),
  .packet_imbalance(res.data.packet_imbalance));
